// ===== src/fcc_pkg.sv =====
`timescale 1ns / 1ps

package fcc_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CHANNEL_BITS = 8;
    localparam int VALUE_BITS   = FRAC_BITS + 2;

    localparam int NUM_MAPS  = 5;
    localparam int MAX_KNOTS = 5;
    localparam int NUM_CH    = 3;

    localparam int SEG_BITS  = $clog2(MAX_KNOTS - 1);
    localparam int KNOT_BITS = $clog2(MAX_KNOTS);
    localparam int MAP_BITS  = $clog2(NUM_MAPS);

    localparam int unsigned ONE_FIX  = 1 << FRAC_BITS;
    localparam int unsigned CHAN_MAX = (1 << CHANNEL_BITS) - 1;

    // map selector codes, maps in between follow in table order
    typedef logic [2:0] func_t;
    localparam func_t FUNC_NONE    = 3'd0;
    localparam func_t FUNC_VIRIDIS = 3'd1;
    localparam func_t FUNC_PLASMA  = 3'd5;

    typedef logic [FRAC_BITS:0]      fix_t;
    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [SEG_BITS-1:0]     seg_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] norm_value;
        func_t                        func;
    } in_word_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } out_word_t;

    // channel order in all tables: red, green, blue
    typedef chan_t [NUM_CH-1:0]    rgb_t;
    typedef fix_t  [MAX_KNOTS-1:0] pos_row_t;
    typedef pos_row_t [NUM_MAPS-1:0] pos_tab_t;
    typedef rgb_t  [MAX_KNOTS-1:0] col_row_t;
    typedef col_row_t [NUM_MAPS-1:0] col_tab_t;
    typedef seg_t  [NUM_MAPS-1:0]  seg_tab_t;

    // knot positions in hundredths: viridis, inferno, rdylgn, blues, plasma
    localparam int unsigned MAP_POS [NUM_MAPS][MAX_KNOTS] = '{
        '{0, 25, 50, 75, 100},
        '{0, 33, 66, 100, 100},
        '{0, 50, 100, 100, 100},
        '{0, 100, 100, 100, 100},
        '{0, 33, 66, 100, 100}
    };

    // knot colors in thousandths
    localparam int unsigned MAP_COL [NUM_MAPS][MAX_KNOTS][NUM_CH] = '{
        '{'{267, 4, 329}, '{192, 408, 557}, '{208, 718, 475},
          '{565, 820, 251}, '{992, 906, 145}},
        '{'{0, 0, 0}, '{737, 216, 329}, '{976, 557, 35},
          '{988, 996, 643}, '{988, 996, 643}},
        '{'{843, 188, 153}, '{996, 878, 545}, '{102, 596, 314},
          '{102, 596, 314}, '{102, 596, 314}},
        '{'{968, 945, 945}, '{31, 188, 420}, '{31, 188, 420},
          '{31, 188, 420}, '{31, 188, 420}},
        '{'{50, 30, 528}, '{798, 280, 469}, '{973, 580, 254},
          '{940, 975, 131}, '{940, 975, 131}}
    };

    localparam int unsigned MAP_NSEG [NUM_MAPS] = '{4, 3, 2, 1, 3};

    function automatic fix_t knot_pos(input int unsigned hundredths);
        return fix_t'((hundredths * ONE_FIX + 50) / 100);
    endfunction

    function automatic chan_t knot_col(input int unsigned thousandths);
        return chan_t'((thousandths * CHAN_MAX + 500) / 1000);
    endfunction

    function automatic pos_tab_t pos_table();
        pos_tab_t tab;
        for (int m = 0; m < NUM_MAPS; m++) begin
            for (int k = 0; k < MAX_KNOTS; k++) begin
                tab[m][k] = knot_pos(MAP_POS[m][k]);
            end
        end
        return tab;
    endfunction

    function automatic col_tab_t col_table();
        col_tab_t tab;
        for (int m = 0; m < NUM_MAPS; m++) begin
            for (int k = 0; k < MAX_KNOTS; k++) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    tab[m][k][c] = knot_col(MAP_COL[m][k][c]);
                end
            end
        end
        return tab;
    endfunction

    function automatic seg_tab_t last_seg_table();
        seg_tab_t tab;
        for (int m = 0; m < NUM_MAPS; m++) begin
            tab[m] = seg_t'(MAP_NSEG[m] - 1);
        end
        return tab;
    endfunction

endpackage

// ===== src/false_color_colormap.sv =====
`timescale 1ns / 1ps

// False-color colormap: each input word carries a signed value with FRAC_BITS
// fraction bits and a map selector; the value is clamped to 0..1, the segment
// of the chosen map that holds it is found, and each channel is interpolated
// between the segment's two knot colors with round-to-nearest. The block
// takes one word per clock while s_ready is high and returns one color word
// per input word, in order. It has one stage for clamp and segment lookup,
// one for the products, one for the sum, and then a restoring divider by
// the segment width that settles one quotient bit per stage. Every stage
// has its own valid bit and moves up whenever the stage after it moves or
// is empty, so bubbles close up under a stalled output and nothing is lost
// or repeated. Selector 0 and the unused codes 6 and 7 give white.
module false_color_colormap (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  fcc_pkg::in_word_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output fcc_pkg::out_word_t   m_data
);

    localparam int DIV_STAGES = fcc_pkg::CHANNEL_BITS;
    localparam int NUM_STAGES = 3 + DIV_STAGES;
    localparam int NUM_W      = fcc_pkg::CHANNEL_BITS + fcc_pkg::FRAC_BITS + 1;
    localparam int NUM_CH     = fcc_pkg::NUM_CH;

    localparam fcc_pkg::pos_tab_t POS_TAB  = fcc_pkg::pos_table();
    localparam fcc_pkg::col_tab_t COL_TAB  = fcc_pkg::col_table();
    localparam fcc_pkg::seg_tab_t LAST_SEG = fcc_pkg::last_seg_table();

    typedef logic [NUM_W-1:0] num_t;

    // after clamp and segment lookup
    typedef struct packed {
        logic          white;
        fcc_pkg::fix_t den;
        fcc_pkg::fix_t dt_lo;
        fcc_pkg::fix_t dt_hi;
        fcc_pkg::rgb_t c0;
        fcc_pkg::rgb_t c1;
    } seg_word_t;

    // weighted knot colors
    typedef struct packed {
        logic                    white;
        fcc_pkg::fix_t           den;
        num_t [NUM_CH-1:0]       prod_lo;
        num_t [NUM_CH-1:0]       prod_hi;
    } prod_word_t;

    // divider state: partial remainder and quotient bits found so far
    typedef struct packed {
        logic              white;
        fcc_pkg::fix_t     den;
        num_t [NUM_CH-1:0] rem;
        fcc_pkg::rgb_t     quo;
    } div_word_t;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;

    seg_word_t  seg_reg;
    seg_word_t  seg_next;
    prod_word_t prod_reg;
    prod_word_t prod_next;
    div_word_t  div_reg  [DIV_STAGES+1];
    div_word_t  div_next [DIV_STAGES+1];

    // ---------------------------------------------------------------------
    // flow control: a stage loads when it is empty or its contents move on
    // ---------------------------------------------------------------------
    always_comb begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        if (load[0]) begin
            valid_next[0] = s_valid;
        end else begin
            valid_next[0] = valid_reg[0];
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (load[i]) begin
                valid_next[i] = valid_reg[i-1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    assign s_ready = load[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 1: clamp to 0..1, pick map and segment, fetch knots
    // ---------------------------------------------------------------------
    always_comb begin
        fcc_pkg::fix_t                t;
        logic                         white;
        logic [fcc_pkg::MAP_BITS-1:0] map_idx;
        fcc_pkg::pos_row_t            pos_row;
        fcc_pkg::seg_t                last_seg;
        fcc_pkg::seg_t                seg;
        logic [fcc_pkg::KNOT_BITS-1:0] lo_k;
        logic [fcc_pkg::KNOT_BITS-1:0] hi_k;
        fcc_pkg::fix_t                p0;
        fcc_pkg::fix_t                p1;

        // negative goes to zero, anything above one goes to one
        if (s_data.norm_value[fcc_pkg::VALUE_BITS-1]) begin
            t = '0;
        end else if (s_data.norm_value[fcc_pkg::FRAC_BITS:0]
                     > fcc_pkg::fix_t'(fcc_pkg::ONE_FIX)) begin
            t = fcc_pkg::fix_t'(fcc_pkg::ONE_FIX);
        end else begin
            t = s_data.norm_value[fcc_pkg::FRAC_BITS:0];
        end

        // selector none and the unused codes give white; the map lookup
        // then runs on the first map and its result is dropped at the output
        white = (s_data.func == fcc_pkg::FUNC_NONE) || (s_data.func > fcc_pkg::FUNC_PLASMA);
        if (white) begin
            map_idx = '0;
        end else begin
            map_idx = fcc_pkg::MAP_BITS'(s_data.func - fcc_pkg::FUNC_VIRIDIS);
        end

        pos_row  = POS_TAB[map_idx];
        last_seg = LAST_SEG[map_idx];

        // first segment whose upper knot lies above t; knots rise, so the
        // last passed boundary wins, and t = 1 stays in the last segment
        seg = '0;
        for (int i = 1; i < fcc_pkg::MAX_KNOTS - 1; i++) begin
            if (fcc_pkg::seg_t'(i) <= last_seg && t >= pos_row[i]) begin
                seg = fcc_pkg::seg_t'(i);
            end
        end

        lo_k = fcc_pkg::KNOT_BITS'(seg);
        hi_k = lo_k + 1'b1;
        p0   = pos_row[lo_k];
        p1   = pos_row[hi_k];

        seg_next.white = white;
        seg_next.den   = p1 - p0;
        seg_next.dt_lo = t - p0;
        seg_next.dt_hi = p1 - t;
        seg_next.c0    = COL_TAB[map_idx][lo_k];
        seg_next.c1    = COL_TAB[map_idx][hi_k];
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            seg_reg <= seg_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 2: c0 * (p1 - t) and c1 * (t - p0) per channel
    // ---------------------------------------------------------------------
    always_comb begin
        prod_next.white = seg_reg.white;
        prod_next.den   = seg_reg.den;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            prod_next.prod_lo[ch] = num_t'(seg_reg.c0[ch]) * num_t'(seg_reg.dt_hi);
            prod_next.prod_hi[ch] = num_t'(seg_reg.c1[ch]) * num_t'(seg_reg.dt_lo);
        end
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            prod_reg <= prod_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 3: numerator with half the width added for rounding, then one
    // restoring divider step per stage, most significant quotient bit first
    // ---------------------------------------------------------------------
    always_comb begin
        num_t trial;

        div_next[0].white = prod_reg.white;
        div_next[0].den   = prod_reg.den;
        div_next[0].quo   = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            div_next[0].rem[ch] = prod_reg.prod_lo[ch] + prod_reg.prod_hi[ch]
                                  + num_t'(prod_reg.den >> 1);
        end

        // the numerator stays below den << CHANNEL_BITS, so the quotient
        // fits the channel width and never saturates
        for (int k = 1; k <= DIV_STAGES; k++) begin
            div_next[k] = div_reg[k-1];
            for (int ch = 0; ch < NUM_CH; ch++) begin
                trial = num_t'(div_reg[k-1].den) << (DIV_STAGES - k);
                if (div_reg[k-1].rem[ch] >= trial) begin
                    div_next[k].rem[ch] = div_reg[k-1].rem[ch] - trial;
                    div_next[k].quo[ch][DIV_STAGES-k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k <= DIV_STAGES; k++) begin
            if (load[k+2]) begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // ---------------------------------------------------------------------
    // output word: last divider stage doubles as the output register
    // ---------------------------------------------------------------------
    always_comb begin
        if (div_reg[DIV_STAGES].white) begin
            m_data.red   = '1;
            m_data.green = '1;
            m_data.blue  = '1;
        end else begin
            m_data.red   = div_reg[DIV_STAGES].quo[0];
            m_data.green = div_reg[DIV_STAGES].quo[1];
            m_data.blue  = div_reg[DIV_STAGES].quo[2];
        end
    end

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------

    // an empty output stage means a bubble somewhere, so input is open
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input closed although output stage is empty");

    // t sits inside its segment: both distances add up to its width
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[0] |-> (fcc_pkg::FRAC_BITS+1)'(seg_reg.dt_lo + seg_reg.dt_hi) == seg_reg.den
                         && seg_reg.den != '0)
        else $error("segment lookup out of range");

    // a finished division leaves a remainder below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> div_reg[DIV_STAGES].rem[0] < num_t'(div_reg[DIV_STAGES].den)
                 && div_reg[DIV_STAGES].rem[1] < num_t'(div_reg[DIV_STAGES].den)
                 && div_reg[DIV_STAGES].rem[2] < num_t'(div_reg[DIV_STAGES].den))
        else $error("divider remainder not reduced");

endmodule

// ===== dv/tb_false_color_colormap.sv =====
`timescale 1ns / 1ps

module tb_false_color_colormap;

    // selector codes without a name in the package
    localparam fcc_pkg::func_t SEL_INFERNO    = 3'd2;
    localparam fcc_pkg::func_t SEL_RDYLGN     = 3'd3;
    localparam fcc_pkg::func_t SEL_BLUES      = 3'd4;
    localparam fcc_pkg::func_t SEL_UNUSED_LO  = 3'd6;
    localparam fcc_pkg::func_t SEL_UNUSED_HI  = 3'd7;

    localparam int PIPE_LATENCY = 3 + fcc_pkg::CHANNEL_BITS;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_WORDS = 1900;

    typedef logic signed [fcc_pkg::VALUE_BITS-1:0] value_t;

    // knot positions in hundredths, per map in selector order
    localparam int unsigned HUND_POS [fcc_pkg::NUM_MAPS][fcc_pkg::MAX_KNOTS] = '{
        '{0, 25, 50, 75, 100},
        '{0, 33, 66, 100, 100},
        '{0, 50, 100, 100, 100},
        '{0, 100, 100, 100, 100},
        '{0, 33, 66, 100, 100}
    };

    // knot colors in thousandths, red/green/blue
    localparam int unsigned
        MILLI_COL [fcc_pkg::NUM_MAPS][fcc_pkg::MAX_KNOTS][fcc_pkg::NUM_CH] = '{
        '{'{267, 4, 329}, '{192, 408, 557}, '{208, 718, 475},
          '{565, 820, 251}, '{992, 906, 145}},
        '{'{0, 0, 0}, '{737, 216, 329}, '{976, 557, 35},
          '{988, 996, 643}, '{988, 996, 643}},
        '{'{843, 188, 153}, '{996, 878, 545}, '{102, 596, 314},
          '{102, 596, 314}, '{102, 596, 314}},
        '{'{968, 945, 945}, '{31, 188, 420}, '{31, 188, 420},
          '{31, 188, 420}, '{31, 188, 420}},
        '{'{50, 30, 528}, '{798, 280, 469}, '{973, 580, 254},
          '{940, 975, 131}, '{940, 975, 131}}
    };

    localparam int unsigned SEG_COUNT [fcc_pkg::NUM_MAPS] = '{4, 3, 2, 1, 3};

    // one word waiting to be sent; drain_first holds it back until the
    // pipeline has emptied
    typedef struct {
        fcc_pkg::in_word_t word;
        bit                drain_first;
    } stim_word_t;

    // expected color with the word that caused it, for messages
    typedef struct {
        fcc_pkg::out_word_t color;
        fcc_pkg::in_word_t  src;
    } color_check_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    fcc_pkg::in_word_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    fcc_pkg::out_word_t m_data;

    stim_word_t   pending_words[$];
    color_check_t expected_colors[$];
    stim_word_t   next_word;
    color_check_t want;
    color_check_t exp_head;

    int mismatches = 0;
    int tx_gap_left;
    int tx_calm_left;
    int rx_stall_left;
    int rx_calm_left;
    int idle_cycles;

    false_color_colormap dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // color predictor
    // ------------------------------------------------------------------

    // knot position on the fixed-point axis, halves round up
    function automatic longint unsigned hund_to_fix(int unsigned hund);
        return (longint'(hund) * (longint'(1) << fcc_pkg::FRAC_BITS) + 50) / 100;
    endfunction

    // knot color as a channel code, halves round up
    function automatic longint unsigned milli_to_code(int unsigned milli);
        return (longint'(milli) * ((longint'(1) << fcc_pkg::CHANNEL_BITS) - 1) + 500)
               / 1000;
    endfunction

    function automatic fcc_pkg::out_word_t map_color(fcc_pkg::in_word_t w);
        longint unsigned    t, p0, p1, den, c0, c1;
        longint unsigned    code [fcc_pkg::NUM_CH];
        longint unsigned    one_fix;
        int                 v;
        int                 m;
        int                 seg;
        fcc_pkg::out_word_t res;

        one_fix = longint'(1) << fcc_pkg::FRAC_BITS;
        v = $signed(w.norm_value);

        // clamp into 0..1
        if (v < 0)
            t = 0;
        else if (longint'(v) > longint'(one_fix))
            t = one_fix;
        else
            t = v;

        // none and the unused codes give white
        if (w.func == fcc_pkg::FUNC_NONE || w.func > fcc_pkg::FUNC_PLASMA) begin
            res.red   = fcc_pkg::chan_t'(fcc_pkg::CHAN_MAX);
            res.green = fcc_pkg::chan_t'(fcc_pkg::CHAN_MAX);
            res.blue  = fcc_pkg::chan_t'(fcc_pkg::CHAN_MAX);
            return res;
        end

        m = int'(w.func - fcc_pkg::FUNC_VIRIDIS);

        // first segment whose upper knot lies above t, else the last one
        seg = SEG_COUNT[m] - 1;
        for (int i = 0; i < SEG_COUNT[m]; i++) begin
            if (t < hund_to_fix(HUND_POS[m][i+1])) begin
                seg = i;
                break;
            end
        end

        p0 = hund_to_fix(HUND_POS[m][seg]);
        p1 = hund_to_fix(HUND_POS[m][seg+1]);
        if (t < p0)
            t = p0;
        if (t > p1)
            t = p1;
        den = p1 - p0;

        for (int c = 0; c < fcc_pkg::NUM_CH; c++) begin
            c0 = milli_to_code(MILLI_COL[m][seg][c]);
            c1 = milli_to_code(MILLI_COL[m][seg+1][c]);
            if (den == 0)
                code[c] = c0;
            else
                code[c] = (c0 * (p1 - t) + c1 * (t - p0) + den / 2) / den;
        end

        res.red   = fcc_pkg::chan_t'(code[0]);
        res.green = fcc_pkg::chan_t'(code[1]);
        res.blue  = fcc_pkg::chan_t'(code[2]);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_word(int value, fcc_pkg::func_t sel, bit drain);
        stim_word_t sw;
        sw.word.norm_value = value_t'(value);
        sw.word.func       = sel;
        sw.drain_first     = drain;
        pending_words.insert(pending_words.size(), sw);
    endtask

    // mostly inside 0..1, some close to a knot, the rest anywhere
    function automatic value_t pick_value();
        int r;
        int knot;
        r = $urandom_range(0, 99);
        if (r < 55)
            return value_t'($urandom_range(0, fcc_pkg::ONE_FIX));
        if (r < 75) begin
            case ($urandom_range(0, 6))
                0:       knot = 0;
                1:       knot = 16384;
                2:       knot = 21627;
                3:       knot = 32768;
                4:       knot = 43254;
                5:       knot = 49152;
                default: knot = fcc_pkg::ONE_FIX;
            endcase
            return value_t'(knot + $urandom_range(0, 6) - 3);
        end
        return value_t'($urandom_range(0, (1 << fcc_pkg::VALUE_BITS) - 1));
    endfunction

    function automatic fcc_pkg::func_t pick_func();
        if ($urandom_range(0, 99) < 85)
            return fcc_pkg::func_t'($urandom_range(fcc_pkg::FUNC_VIRIDIS,
                                                   fcc_pkg::FUNC_PLASMA));
        case ($urandom_range(0, 2))
            0:       return fcc_pkg::FUNC_NONE;
            1:       return SEL_UNUSED_LO;
            default: return SEL_UNUSED_HI;
        endcase
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string what, int got, int want_val);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want_val);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // driver: sends pending words, predicts each accepted one
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            tx_gap_left  = 0;
            tx_calm_left = 0;
        end else begin
            // word taken at this edge: predict its color
            if (s_valid && s_ready) begin
                want.color = map_color(s_data);
                want.src   = s_data;
                expected_colors.insert(expected_colors.size(), want);
            end

            if (!s_valid || s_ready) begin
                if (tx_gap_left != 0) begin
                    s_valid    <= 1'b0;
                    tx_gap_left = tx_gap_left - 1;
                end else if (pending_words.size() != 0 &&
                             !(pending_words[0].drain_first &&
                               expected_colors.size() != 0)) begin
                    next_word = pending_words.pop_front();
                    s_data  <= next_word.word;
                    s_valid <= 1'b1;
                    // gap after this word, none during a calm stretch
                    if (tx_calm_left != 0) begin
                        tx_calm_left = tx_calm_left - 1;
                        tx_gap_left  = 0;
                    end else begin
                        if ($urandom_range(0, 199) == 0)
                            tx_calm_left = 60;
                        tx_gap_left = pick_gap();
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random output stalls, compares each color word
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            rx_stall_left = 0;
            rx_calm_left  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_colors.size() == 0) begin
                    report_mismatch("color word with nothing pending", int'(m_data), 0);
                end else begin
                    exp_head = expected_colors.pop_front();
                    if (m_data.red !== exp_head.color.red)
                        report_mismatch($sformatf("red, value %0d map %0d",
                                        $signed(exp_head.src.norm_value),
                                        exp_head.src.func),
                                        int'(m_data.red), int'(exp_head.color.red));
                    if (m_data.green !== exp_head.color.green)
                        report_mismatch($sformatf("green, value %0d map %0d",
                                        $signed(exp_head.src.norm_value),
                                        exp_head.src.func),
                                        int'(m_data.green), int'(exp_head.color.green));
                    if (m_data.blue !== exp_head.color.blue)
                        report_mismatch($sformatf("blue, value %0d map %0d",
                                        $signed(exp_head.src.norm_value),
                                        exp_head.src.func),
                                        int'(m_data.blue), int'(exp_head.color.blue));
                end
            end

            if (rx_stall_left != 0) begin
                m_ready      <= 1'b0;
                rx_stall_left = rx_stall_left - 1;
            end else begin
                m_ready <= 1'b1;
                if (rx_calm_left != 0) begin
                    rx_calm_left = rx_calm_left - 1;
                end else begin
                    if ($urandom_range(0, 299) == 0)
                        rx_calm_left = 80;
                    else if ($urandom_range(0, 3) == 0)
                        rx_stall_left = pick_gap();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any word moving on either side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles = 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        // directed: clamp extremes, knot edges, every map, white codes
        push_word(0,       fcc_pkg::FUNC_NONE,     1'b0);
        push_word(-131072, fcc_pkg::FUNC_VIRIDIS,  1'b0);
        push_word(131071,  fcc_pkg::FUNC_VIRIDIS,  1'b0);
        push_word(65536,   fcc_pkg::FUNC_VIRIDIS,  1'b0);
        push_word(16383,   fcc_pkg::FUNC_VIRIDIS,  1'b0);
        push_word(16384,   fcc_pkg::FUNC_VIRIDIS,  1'b0);
        push_word(49152,   fcc_pkg::FUNC_VIRIDIS,  1'b0);
        push_word(65536,   SEL_INFERNO,            1'b0);
        push_word(21626,   SEL_INFERNO,            1'b0);
        push_word(21627,   SEL_INFERNO,            1'b0);
        push_word(65537,   SEL_RDYLGN,             1'b0);
        push_word(32767,   SEL_RDYLGN,             1'b0);
        push_word(32768,   SEL_RDYLGN,             1'b0);
        push_word(-1,      SEL_BLUES,              1'b0);
        push_word(32768,   SEL_BLUES,              1'b0);
        push_word(65535,   SEL_BLUES,              1'b0);
        push_word(0,       fcc_pkg::FUNC_PLASMA,   1'b0);
        push_word(43254,   fcc_pkg::FUNC_PLASMA,   1'b0);
        push_word(65536,   fcc_pkg::FUNC_PLASMA,   1'b0);
        push_word(12345,   SEL_UNUSED_LO,          1'b0);
        push_word(-5,      SEL_UNUSED_HI,          1'b0);

        // random part, with the pipeline drained before a few words
        for (int i = 0; i < RANDOM_WORDS; i++)
            push_word(pick_value(), pick_func(), (i == 0 || i == 600 || i == 1300));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_valid || expected_colors.size() != 0)
            @(posedge aclk);
        // catch any extra color word that trails the last one
        repeat (3 * PIPE_LATENCY) @(posedge aclk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
